>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the ray/box intersection RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define RBS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication checked on every rising clock edge outside reset.
`define RBS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> hw/rtl/rbsi_pkg.sv
// Shared types, constants and helpers for the ray/box slab intersection block.
// No dependencies; used by every module of the block except rbsi_div_pipe.
`timescale 1ns / 1ps
`default_nettype none

package rbsi_pkg;

	localparam int DATA_W = 32;
	localparam int THR_W  = 31;
	localparam int NORM_W = 2;
	localparam int CFG_W  = 3;

	typedef logic signed [DATA_W-1:0] fix_t;
	typedef logic signed [NORM_W-1:0] norm_t;

	typedef enum logic [CFG_W-1:0] {
		CFG_C1X,
		CFG_C1Y,
		CFG_C1Z,
		CFG_C2X,
		CFG_C2Y,
		CFG_C2Z,
		CFG_DTHR,
		CFG_PTHR
	} cfg_idx_t;

	// Per-axis box setup handed to the lanes.
	typedef struct packed {
		fix_t             hi;
		fix_t             lo;
		logic [THR_W-1:0] dir_thr;
		logic [THR_W-1:0] pos_thr;
	} axis_cfg_t;

	localparam norm_t NORM_POS  = 2'sb01;
	localparam norm_t NORM_NEG  = 2'sb11;
	localparam norm_t NORM_NONE = 2'sb00;

	localparam fix_t FIX_MAX = 32'sh7FFF_FFFF;
	localparam fix_t FIX_MIN = 32'sh8000_0000;

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

	function automatic fix_t sat_fix(input logic signed [65:0] x);
		fix_t r;
		if (x > SAT_HI) begin
			r = FIX_MAX;
		end else if (x < SAT_LO) begin
			r = FIX_MIN;
		end else begin
			r = x[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rbsi_div_pipe.sv
// Pipelined restoring divider: 2^(QW-1) divided by an unsigned divisor, one
// quotient bit per stage, with a side payload that travels alongside.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_div_pipe #(
	parameter int QW     = 33,
	parameter int DW     = 32,
	parameter int SIDE_W = 66
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [DW-1:0]     divisor,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic      [QW-1:0]     quot,
	output logic      [SIDE_W-1:0] side_out
);

	logic [DW-1:0]     rem_s  [QW];
	logic [QW-1:0]     quot_s [QW];
	logic [DW-1:0]     div_s  [QW];
	logic [SIDE_W-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0]     rem_prev;
		logic [QW-1:0]     quot_prev;
		logic [DW-1:0]     div_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [DW:0]       trial;
		logic [DW:0]       diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_prev  = '0;
			assign quot_prev = '0;
			assign div_prev  = divisor;
			assign side_prev = side_in;
		end else begin : g_next
			assign rem_prev  = rem_s[k-1];
			assign quot_prev = quot_s[k-1];
			assign div_prev  = div_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// The dividend is a single one at its top bit, so only the first stage shifts in a one.
		assign trial = {rem_prev, (k == 0) ? 1'b1 : 1'b0};
		assign diff  = trial - {1'b0, div_prev};
		assign ge    = (trial >= {1'b0, div_prev});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				quot_s[k] <= {quot_prev[QW-2:0], ge};
				div_s[k]  <= div_prev;
				side_s[k] <= side_prev;
			end
		end
	end

	assign quot     = quot_s[QW-1];
	assign side_out = side_s[QW-1];

endmodule

`default_nettype wire

>>> hw/rtl/rbsi_slab_lane.sv
// One axis of the slab test: corner deltas, reciprocal direction and the
// entry/exit distances. Uses rbsi_pkg and rbsi_div_pipe.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_slab_lane #(
	parameter int                FRAC_BITS           = 16,
	parameter logic signed [31:0] FALLBACK_RECIPROCAL = 32'sh7FFF_FFFF
) (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire rbsi_pkg::fix_t     org,
	input  wire rbsi_pkg::fix_t     dir,
	input  wire rbsi_pkg::axis_cfg_t cfg,
	output rbsi_pkg::fix_t          tmin,
	output rbsi_pkg::fix_t          tmax
);

	localparam int QW     = 2 * FRAC_BITS + 1;
	localparam int SIDE_W = 2 * rbsi_pkg::DATA_W + 2;

	logic signed [33:0] dh_w, dl_w, dh_abs, dl_abs, thr_w;
	rbsi_pkg::fix_t     dh_c, dl_c;
	logic [31:0]        dabs_c;
	logic               fb_c;

	assign thr_w  = {3'b000, cfg.pos_thr};
	assign dh_w   = {{2{cfg.hi[31]}}, cfg.hi} - {{2{org[31]}}, org};
	assign dl_w   = {{2{cfg.lo[31]}}, cfg.lo} - {{2{org[31]}}, org};
	assign dh_abs = dh_w[33] ? -dh_w : dh_w;
	assign dl_abs = dl_w[33] ? -dl_w : dl_w;
	assign dh_c   = rbsi_pkg::sat_fix((dh_abs < thr_w) ? {{32{1'b0}}, thr_w}
		: {{32{dh_w[33]}}, dh_w});
	assign dl_c   = rbsi_pkg::sat_fix((dl_abs < thr_w) ? {{32{1'b0}}, thr_w}
		: {{32{dl_w[33]}}, dl_w});
	assign dabs_c = dir[31] ? (~dir + 32'd1) : dir;
	assign fb_c   = (dabs_c == 32'd0) || (dabs_c < {1'b0, cfg.dir_thr});

	rbsi_pkg::fix_t dh_s1, dl_s1;
	logic [31:0]    dabs_s1;
	logic           fb_s1, neg_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dh_s1   <= dh_c;
			dl_s1   <= dl_c;
			dabs_s1 <= dabs_c;
			fb_s1   <= fb_c;
			neg_s1  <= dir[31];
		end
	end

	logic [QW-1:0]     quot;
	logic [SIDE_W-1:0] side_out;

	rbsi_div_pipe #(
		.QW     (QW),
		.DW     (rbsi_pkg::DATA_W),
		.SIDE_W (SIDE_W)
	) u_div (
		.clk      (clk),
		.en       (en),
		.divisor  (dabs_s1),
		.side_in  ({dh_s1, dl_s1, fb_s1, neg_s1}),
		.quot     (quot),
		.side_out (side_out)
	);

	rbsi_pkg::fix_t dh_d, dl_d, recip_c;
	logic           fb_d, neg_d;
	logic [63:0]    q64;

	assign {dh_d, dl_d, fb_d, neg_d} = side_out;
	assign q64 = 64'(quot);

	always_comb begin
		if (fb_d) begin
			recip_c = FALLBACK_RECIPROCAL;
		end else if (!neg_d) begin
			recip_c = (q64 > 64'h7FFF_FFFF) ? rbsi_pkg::FIX_MAX : q64[31:0];
		end else begin
			recip_c = (q64 > 64'h8000_0000) ? rbsi_pkg::FIX_MIN : (~q64[31:0] + 32'd1);
		end
	end

	rbsi_pkg::fix_t dh_s2, dl_s2, recip_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			dh_s2    <= dh_d;
			dl_s2    <= dl_d;
			recip_s2 <= recip_c;
		end
	end

	logic signed [63:0] ph_s3, pl_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s3 <= dh_s2 * recip_s2;
			pl_s3 <= dl_s2 * recip_s2;
		end
	end

	logic signed [63:0] sh_h, sh_l;
	rbsi_pkg::fix_t     th, tl;

	// Arithmetic shift rounds toward minus infinity.
	assign sh_h = ph_s3 >>> FRAC_BITS;
	assign sh_l = pl_s3 >>> FRAC_BITS;
	assign th   = rbsi_pkg::sat_fix({{2{sh_h[63]}}, sh_h});
	assign tl   = rbsi_pkg::sat_fix({{2{sh_l[63]}}, sh_l});

	rbsi_pkg::fix_t tmin_s4, tmax_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			tmin_s4 <= (tl < th) ? tl : th;
			tmax_s4 <= (tl < th) ? th : tl;
		end
	end

	assign tmin = tmin_s4;
	assign tmax = tmax_s4;

endmodule

`default_nettype wire

>>> hw/rtl/rbsi_point_lane.sv
// One axis of the hit point and face normal, two stages, zero on a miss.
// Uses rbsi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbsi_point_lane #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic                hit,
	input  wire rbsi_pkg::fix_t      org,
	input  wire rbsi_pkg::fix_t      dir,
	input  wire rbsi_pkg::fix_t      enter,
	input  wire rbsi_pkg::axis_cfg_t cfg,
	output rbsi_pkg::fix_t           point,
	output rbsi_pkg::norm_t          normal
);

	logic signed [63:0] prod_s1;
	rbsi_pkg::fix_t     org_s1;
	logic               hit_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= dir * enter;
			org_s1  <= org;
			hit_s1  <= hit;
		end
	end

	logic signed [63:0] sh;
	logic signed [65:0] sum;
	rbsi_pkg::fix_t     p;
	logic signed [33:0] dhi, dlo, ahi, alo, thr_w;
	rbsi_pkg::norm_t    n;

	assign sh    = prod_s1 >>> FRAC_BITS;
	assign sum   = {{34{org_s1[31]}}, org_s1} + {{2{sh[63]}}, sh};
	assign p     = rbsi_pkg::sat_fix(sum);
	assign thr_w = {3'b000, cfg.pos_thr};
	assign dhi   = {{2{p[31]}}, p} - {{2{cfg.hi[31]}}, cfg.hi};
	assign dlo   = {{2{p[31]}}, p} - {{2{cfg.lo[31]}}, cfg.lo};
	assign ahi   = dhi[33] ? -dhi : dhi;
	assign alo   = dlo[33] ? -dlo : dlo;

	// The low face wins when the point sits near both faces.
	always_comb begin
		if (alo < thr_w) begin
			n = rbsi_pkg::NORM_NEG;
		end else if (ahi < thr_w) begin
			n = rbsi_pkg::NORM_POS;
		end else begin
			n = rbsi_pkg::NORM_NONE;
		end
	end

	rbsi_pkg::fix_t  point_s2;
	rbsi_pkg::norm_t normal_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			point_s2  <= hit_s1 ? p : '0;
			normal_s2 <= hit_s1 ? n : rbsi_pkg::NORM_NONE;
		end
	end

	assign point  = point_s2;
	assign normal = normal_s2;

endmodule

`default_nettype wire

>>> hw/rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box intersection, slab method, Q16.16 fixed point.
// Uses rbsi_pkg, rbsi_slab_lane, rbsi_point_lane and assert_macros.svh.
//
// Usage:
//   Rays enter on the in_valid/in_ready channel, one beat per ray, and each
//   ray gives exactly one result beat on out_valid/out_ready, in order.
//   The box corners and the two thresholds are set through the write port
//   (cfg_we, cfg_index, cfg_data) while no ray is in flight.
//   Each of the three axis lanes holds a one-bit-per-stage divider for the
//   reciprocal. Throughput is one ray per cycle unless out_ready stalls.
//   When the receiver holds out_ready low with a result waiting, the whole
//   pipeline freezes and in_ready drops; nothing is lost or repeated.
//   Reset clears the pipeline valid bits and loads the default box (unit
//   cube from the origin) with both thresholds at one LSB.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ray_box_slab_intersect #(
	parameter int                FRAC_BITS           = 16,
	parameter logic signed [31:0] FALLBACK_RECIPROCAL = 32'sh7FFF_FFFF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rbsi_pkg::CFG_W-1:0]  cfg_index,
	input  wire logic [31:0]                 cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire rbsi_pkg::fix_t              origin_x,
	input  wire rbsi_pkg::fix_t              origin_y,
	input  wire rbsi_pkg::fix_t              origin_z,
	input  wire rbsi_pkg::fix_t              dir_x,
	input  wire rbsi_pkg::fix_t              dir_y,
	input  wire rbsi_pkg::fix_t              dir_z,
	input  wire rbsi_pkg::fix_t              t_lower,
	input  wire rbsi_pkg::fix_t              t_upper,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             hit,
	output rbsi_pkg::fix_t                   hit_distance,
	output rbsi_pkg::fix_t                   point_x,
	output rbsi_pkg::fix_t                   point_y,
	output rbsi_pkg::fix_t                   point_z,
	output rbsi_pkg::norm_t                  normal_x,
	output rbsi_pkg::norm_t                  normal_y,
	output rbsi_pkg::norm_t                  normal_z
);

	localparam int LANE_LAT = 2 * FRAC_BITS + 5;
	localparam int PIPE_LAT = LANE_LAT + 3;

	typedef struct packed {
		rbsi_pkg::fix_t [2:0] org;
		rbsi_pkg::fix_t [2:0] dir;
		rbsi_pkg::fix_t       tlo;
		rbsi_pkg::fix_t       tup;
	} ray_t;

	// Configuration registers.
	rbsi_pkg::fix_t [2:0]           c1_q, c2_q;
	logic [rbsi_pkg::THR_W-1:0]     dthr_q, pthr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q   <= '{default: 32'sd0};
			c2_q   <= '{default: 32'sd65536};
			dthr_q <= 31'd1;
			pthr_q <= 31'd1;
		end else if (cfg_we) begin
			unique case (rbsi_pkg::cfg_idx_t'(cfg_index))
				rbsi_pkg::CFG_C1X:  c1_q[0] <= cfg_data;
				rbsi_pkg::CFG_C1Y:  c1_q[1] <= cfg_data;
				rbsi_pkg::CFG_C1Z:  c1_q[2] <= cfg_data;
				rbsi_pkg::CFG_C2X:  c2_q[0] <= cfg_data;
				rbsi_pkg::CFG_C2Y:  c2_q[1] <= cfg_data;
				rbsi_pkg::CFG_C2Z:  c2_q[2] <= cfg_data;
				rbsi_pkg::CFG_DTHR: dthr_q  <= cfg_data[rbsi_pkg::THR_W-1:0];
				rbsi_pkg::CFG_PTHR: pthr_q  <= cfg_data[rbsi_pkg::THR_W-1:0];
				default:            dthr_q  <= dthr_q;
			endcase
		end
	end

	rbsi_pkg::axis_cfg_t acfg [3];

	for (genvar a = 0; a < 3; a++) begin : g_cfg
		rbsi_pkg::fix_t c1, c2;
		assign c1 = c1_q[a];
		assign c2 = c2_q[a];
		assign acfg[a].hi      = (c1 > c2) ? c1 : c2;
		assign acfg[a].lo      = (c1 > c2) ? c2 : c1;
		assign acfg[a].dir_thr = dthr_q;
		assign acfg[a].pos_thr = pthr_q;
	end

	// The whole pipeline advances together unless a result is held at the output.
	logic                pipe_en;
	logic [PIPE_LAT-1:0] valid_q;

	assign pipe_en   = !out_valid || out_ready;
	assign in_ready  = pipe_en;
	assign out_valid = valid_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (pipe_en) begin
			valid_q <= {valid_q[PIPE_LAT-2:0], in_valid};
		end
	end

	ray_t ray_in;
	ray_t ray_q [LANE_LAT];

	assign ray_in.org = {origin_z, origin_y, origin_x};
	assign ray_in.dir = {dir_z, dir_y, dir_x};
	assign ray_in.tlo = t_lower;
	assign ray_in.tup = t_upper;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ray_q[0] <= ray_in;
			for (int i = 1; i < LANE_LAT; i++) begin
				ray_q[i] <= ray_q[i-1];
			end
		end
	end

	rbsi_pkg::fix_t tmin [3];
	rbsi_pkg::fix_t tmax [3];

	for (genvar a = 0; a < 3; a++) begin : g_slab
		rbsi_slab_lane #(
			.FRAC_BITS           (FRAC_BITS),
			.FALLBACK_RECIPROCAL (FALLBACK_RECIPROCAL)
		) u_lane (
			.clk  (clk),
			.en   (pipe_en),
			.org  (ray_in.org[a]),
			.dir  (ray_in.dir[a]),
			.cfg  (acfg[a]),
			.tmin (tmin[a]),
			.tmax (tmax[a])
		);
	end

	// Merge: latest entry and earliest exit over the three slabs.
	rbsi_pkg::fix_t enter_c, leave_c, e01, l01, tlo_d, tup_d;
	logic           hit_c;

	assign e01     = (tmin[1] > tmin[0]) ? tmin[1] : tmin[0];
	assign l01     = (tmax[1] < tmax[0]) ? tmax[1] : tmax[0];
	assign enter_c = (tmin[2] > e01) ? tmin[2] : e01;
	assign leave_c = (tmax[2] < l01) ? tmax[2] : l01;
	assign tlo_d   = ray_q[LANE_LAT-1].tlo;
	assign tup_d   = ray_q[LANE_LAT-1].tup;
	assign hit_c   = (leave_c > enter_c) && (enter_c > tlo_d) && (enter_c < tup_d);

	logic                 hit_s1, hit_s2, hit_s3;
	rbsi_pkg::fix_t       enter_s1, dist_s2, dist_s3;
	rbsi_pkg::fix_t [2:0] org_s1, dir_s1;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			hit_s1   <= hit_c;
			enter_s1 <= enter_c;
			org_s1   <= ray_q[LANE_LAT-1].org;
			dir_s1   <= ray_q[LANE_LAT-1].dir;
			hit_s2   <= hit_s1;
			dist_s2  <= hit_s1 ? enter_s1 : '0;
			hit_s3   <= hit_s2;
			dist_s3  <= dist_s2;
		end
	end

	rbsi_pkg::fix_t  pnt [3];
	rbsi_pkg::norm_t nrm [3];

	for (genvar a = 0; a < 3; a++) begin : g_point
		rbsi_point_lane #(
			.FRAC_BITS (FRAC_BITS)
		) u_point (
			.clk    (clk),
			.en     (pipe_en),
			.hit    (hit_s1),
			.org    (org_s1[a]),
			.dir    (dir_s1[a]),
			.enter  (enter_s1),
			.cfg    (acfg[a]),
			.point  (pnt[a]),
			.normal (nrm[a])
		);
	end

	assign hit          = hit_s3;
	assign hit_distance = dist_s3;
	assign point_x      = pnt[0];
	assign point_y      = pnt[1];
	assign point_z      = pnt[2];
	assign normal_x     = nrm[0];
	assign normal_y     = nrm[1];
	assign normal_z     = nrm[2];

	`RBS_ASSERT(a_stall_freeze, clk, arst_n, (!pipe_en |=> $stable(valid_q)), "pipeline moved while stalled")
	`RBS_ASSERT_IMPLY(a_miss_zero, clk, arst_n, out_valid && !hit, hit_distance == '0 && point_x == '0 && point_y == '0 && point_z == '0 && normal_x == rbsi_pkg::NORM_NONE && normal_y == rbsi_pkg::NORM_NONE && normal_z == rbsi_pkg::NORM_NONE, "miss beat carries nonzero payload")
	`RBS_ASSERT_IMPLY(a_normal_code, clk, arst_n, out_valid && hit, normal_x != 2'sb10 && normal_y != 2'sb10 && normal_z != 2'sb10, "face normal out of range")

endmodule

`default_nettype wire
